// ===== src/telemetry_frame_builder_dual_sum_top_macros.svh =====
// Assertion macros for the telemetry frame builder.
// Used by modules that include this header; they need clk and rst_n in scope.
`ifndef TELEMETRY_FRAME_BUILDER_DUAL_SUM_TOP_MACROS_SVH
`define TELEMETRY_FRAME_BUILDER_DUAL_SUM_TOP_MACROS_SVH
`ifndef SYNTH
`define TFB_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define TFB_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TFB_ASSERT_IMP(lbl, ante, cons, msg)
`define TFB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/tfb_pkg.sv =====
// Shared types and constants for the telemetry frame builder.
// No dependencies; imported by tfb_seq, tfb_oreg and the top module.
package tfb_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'hAA;
    localparam logic [7:0] ADDR_RESET = 8'hFF;

    localparam int SLOT_W = 3;

    // Result slots of a start request
    localparam logic [SLOT_W-1:0] SLOT_SYNC = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_ADDR = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_ID   = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_LEN  = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_CHK1 = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_CHK2 = 3'd5;

    // Result slots of a payload request
    localparam logic [SLOT_W-1:0] SLOT_DATA  = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_PCHK1 = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_PCHK2 = 3'd2;

    typedef enum logic
    {
        REQ_START = 1'b0,
        REQ_DATA  = 1'b1
    } req_kind_t;

    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
        logic       stray_error;
    } res_t;

endpackage

// ===== src/tfb_ifs.sv =====
// Channel interfaces for the telemetry frame builder: request, result, config.
// Depends on nothing.
interface tfb_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] frame_id;
    logic [7:0] frame_len;
    logic [7:0] data_byte;
    modport source (output valid, req_type, frame_id, frame_len, data_byte, input ready);
    modport sink   (input valid, req_type, frame_id, frame_len, data_byte, output ready);
endinterface

interface tfb_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
    logic       stray_error;
    modport source (output valid, out_byte, frame_end, run_last, stray_error, input ready);
    modport sink   (input valid, out_byte, frame_end, run_last, stray_error, output ready);
endinterface

interface tfb_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== src/tfb_seq.sv =====
// Request register and slot sequencer: emits one frame byte per cycle while emit_ready is high.
// Depends on tfb_pkg, tfb_ifs and the assertion macro header.
`include "telemetry_frame_builder_dual_sum_top_macros.svh"

module tfb_seq
    import tfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tfb_req_if.sink     req,
    tfb_cfg_if.sink     cfg,
    input  logic        emit_ready,
    output logic        emit_valid,
    output res_t        emit_res
);

    logic                cur_valid_reg;
    req_kind_t           cur_kind_reg;
    logic [7:0]          cur_id_reg;
    logic [7:0]          cur_len_reg;
    logic [7:0]          cur_data_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [7:0]          source_address_reg;
    logic                frame_open_reg;
    logic [7:0]          bytes_remaining_reg;
    logic [7:0]          running_sum_reg;
    logic [7:0]          sum_of_sums_reg;

    logic       is_start;
    logic       stray;
    logic       chk1;
    logic       chk2;
    logic       counts;
    logic       last;
    logic       fire;
    logic [7:0] byte_val;
    logic [7:0] rs_base;
    logic [7:0] ss_base;
    logic [7:0] rs_sum;
    logic [7:0] ss_sum;

    // Decode the current slot
    always_comb
    begin
        is_start = (cur_kind_reg == REQ_START);
        stray    = !is_start && !frame_open_reg;
        chk1     = is_start ? (slot_reg == SLOT_CHK1) : (!stray && slot_reg == SLOT_PCHK1);
        chk2     = is_start ? (slot_reg == SLOT_CHK2) : (!stray && slot_reg == SLOT_PCHK2);
        counts   = !chk1 && !chk2 && !stray;

        byte_val = 8'h00;
        if (is_start)
        begin
            case (slot_reg)
                SLOT_SYNC: byte_val = SYNC_BYTE;
                SLOT_ADDR: byte_val = source_address_reg;
                SLOT_ID:   byte_val = cur_id_reg;
                SLOT_LEN:  byte_val = cur_len_reg;
                SLOT_CHK1: byte_val = running_sum_reg;
                SLOT_CHK2: byte_val = sum_of_sums_reg;
                default:   byte_val = 8'h00;
            endcase
        end
        else if (!stray)
        begin
            case (slot_reg)
                SLOT_DATA:  byte_val = cur_data_reg;
                SLOT_PCHK1: byte_val = running_sum_reg;
                SLOT_PCHK2: byte_val = sum_of_sums_reg;
                default:    byte_val = 8'h00;
            endcase
        end

        last = stray || chk2
            || (is_start && slot_reg == SLOT_LEN && cur_len_reg != 8'd0)
            || (!is_start && slot_reg == SLOT_DATA && bytes_remaining_reg != 8'd1);

        // Sums restart on the sync byte of a new frame
        rs_base = (is_start && slot_reg == SLOT_SYNC) ? 8'd0 : running_sum_reg;
        ss_base = (is_start && slot_reg == SLOT_SYNC) ? 8'd0 : sum_of_sums_reg;
        rs_sum  = rs_base + byte_val;
        ss_sum  = ss_base + rs_sum;

        fire      = cur_valid_reg && emit_ready;
        slot_next = last ? SLOT_SYNC : slot_reg + 3'd1;
    end

    assign emit_valid           = cur_valid_reg;
    assign emit_res.out_byte    = byte_val;
    assign emit_res.frame_end   = chk2;
    assign emit_res.run_last    = last;
    assign emit_res.stray_error = stray;

    assign req.ready = !cur_valid_reg || (fire && last);
    assign cfg.ready = 1'b1;

    // Hold the current request and advance its slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            slot_reg      <= SLOT_SYNC;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                cur_valid_reg <= 1'b1;
                slot_reg      <= SLOT_SYNC;
            end
            else if (fire)
            begin
                cur_valid_reg <= !last;
                slot_reg      <= slot_next;
            end
        end
    end

    // Capture request payload
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cur_kind_reg <= req_kind_t'(req.req_type);
            cur_id_reg   <= req.frame_id;
            cur_len_reg  <= req.frame_len;
            cur_data_reg <= req.data_byte;
        end
    end

    // Source address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_address_reg <= ADDR_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            source_address_reg <= cfg.data;
        end
    end

    // Frame state and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg      <= 1'b0;
            bytes_remaining_reg <= 8'd0;
            running_sum_reg     <= 8'd0;
            sum_of_sums_reg     <= 8'd0;
        end
        else if (fire)
        begin
            if (counts)
            begin
                running_sum_reg <= rs_sum;
                sum_of_sums_reg <= ss_sum;
            end
            if (is_start && slot_reg == SLOT_LEN)
            begin
                bytes_remaining_reg <= cur_len_reg;
                frame_open_reg      <= 1'b1;
            end
            if (!is_start && counts)
            begin
                bytes_remaining_reg <= bytes_remaining_reg - 8'd1;
            end
            if (chk2)
            begin
                frame_open_reg <= 1'b0;
            end
        end
    end

    `TFB_ASSERT_IMP(a_slot_range, cur_valid_reg, slot_reg <= SLOT_CHK2, "slot out of range")
    `TFB_ASSERT_IMP(a_stray_last, fire && stray, last && !chk2, "stray request not single")
    `TFB_ASSERT_NXT(a_close_frame, fire && chk2, !frame_open_reg, "frame still open after checks")

endmodule

// ===== src/tfb_oreg.sv =====
// Result register between the sequencer and the result channel.
// Depends on tfb_pkg and tfb_ifs.
module tfb_oreg
    import tfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  res_t        in_res,
    tfb_res_if.source   res
);

    logic valid_reg;
    res_t res_reg;

    assign in_ready = !valid_reg || res.ready;

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= in_res;
        end
    end

    assign res.valid       = valid_reg;
    assign res.out_byte    = res_reg.out_byte;
    assign res.frame_end   = res_reg.frame_end;
    assign res.run_last    = res_reg.run_last;
    assign res.stray_error = res_reg.stray_error;

endmodule

// ===== src/telemetry_frame_builder_dual_sum_top.sv =====
// Telemetry frame builder: one frame byte per cycle from the slot sequencer when results do not stall.
// A request is held in the request register; its bytes go out through the result register.
// A payload request emits its data byte, plus both check bytes when it closes the frame;
// a start request emits sync, address, ID and length, plus both check bytes for an empty frame.
// Reset: rst_n async active low; clears frame state, sums and valids, address to 0xFF.
module telemetry_frame_builder_dual_sum_top
    import tfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tfb_req_if.sink     req,
    tfb_cfg_if.sink     cfg,
    tfb_res_if.source   res
);

    logic emit_valid;
    logic emit_ready;
    res_t emit_res;

    // Sequence request bytes
    tfb_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .emit_ready (emit_ready),
        .emit_valid (emit_valid),
        .emit_res   (emit_res)
    );

    // Register results
    tfb_oreg u_oreg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (emit_valid),
        .in_ready (emit_ready),
        .in_res   (emit_res),
        .res      (res)
    );

endmodule
